@@ rtl/core/rgb_to_hsv_converter_macros.svh @@
// assertion helpers shared by the rtl
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
`define RHC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RHC_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define RHC_ASSERT(lbl, clk, rstn, prop, msg)
`define RHC_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

@@ rtl/core/rhc_pkg.sv @@
package rhc_pkg;

    localparam int COMP_W = 8;
    localparam int HUE_W = 15;
    // sextant numerator is below 6 * 256
    localparam int NUM_W = 11;

    localparam int HUE_DEG = 60;
    localparam int SAT_SCALE = 255;
    localparam int TURN_DEG = 360;
    localparam int SEXT_GREEN = 2;
    localparam int SEXT_BLUE = 4;
    localparam int SEXT_TURN = 6;

    typedef logic [COMP_W-1:0] comp_t;

    typedef struct packed {
        logic  grey;
        comp_t mx;
        comp_t alpha;
    } side_t;

endpackage

@@ rtl/core/rhc_div_pipe.sv @@
module rhc_div_pipe #(
    parameter int STEP = 4,
    parameter int STAGES = 4
) (
    input  logic                                      aclk,
    input  logic [STAGES-1:0]                         stage_en,
    input  logic [rhc_pkg::COMP_W+STEP*STAGES-1:0]    dividend,
    input  logic [rhc_pkg::COMP_W-1:0]                divisor,
    output logic [STEP*STAGES-1:0]                    quotient
);

    localparam int QPW = STEP * STAGES;
    localparam int DW = rhc_pkg::COMP_W;

    // partial state between stages; the last stage keeps only the quotient
    logic [DW-1:0]  rem_reg [STAGES-1];
    logic [QPW-1:0] dvd_reg [STAGES-1];
    logic [QPW-1:0] quo_reg [STAGES];
    logic [DW-1:0]  dsr_reg [STAGES-1];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [DW-1:0]  rem_in;
        logic [QPW-1:0] dvd_in;
        logic [QPW-1:0] quo_in;
        logic [DW-1:0]  dsr_in;
        logic [DW-1:0]  rem_next;
        logic [QPW-1:0] dvd_next;
        logic [QPW-1:0] quo_next;
        logic [DW:0]    trial;

        if (s == 0) begin : g_first
            // dividend is known to give a quotient below 2^QPW, so this is below divisor
            assign rem_in = dividend[DW+QPW-1:QPW];
            assign dvd_in = dividend[QPW-1:0];
            assign quo_in = '0;
            assign dsr_in = divisor;
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign dvd_in = dvd_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign dsr_in = dsr_reg[s-1];
        end

        // restoring division, STEP quotient bits per stage
        always_comb begin
            rem_next = rem_in;
            dvd_next = dvd_in;
            quo_next = quo_in;
            trial = '0;
            for (int k = 0; k < STEP; k++) begin
                trial = {rem_next, dvd_next[QPW-1]};
                dvd_next = {dvd_next[QPW-2:0], 1'b0};
                if (trial >= {1'b0, dsr_in}) begin
                    rem_next = DW'(trial - {1'b0, dsr_in});
                    quo_next = {quo_next[QPW-2:0], 1'b1};
                end else begin
                    rem_next = trial[DW-1:0];
                    quo_next = {quo_next[QPW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[s]) begin
                quo_reg[s] <= quo_next;
            end
        end

        if (s < STAGES - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (stage_en[s]) begin
                    rem_reg[s] <= rem_next;
                    dvd_reg[s] <= dvd_next;
                    dsr_reg[s] <= dsr_in;
                end
            end
        end
    end

    assign quotient = quo_reg[STAGES-1];

endmodule

@@ rtl/core/rgb_to_hsv_converter.sv @@
// RGB to HSV converter: one 8-bit RGBA pixel in, hue / saturation / value / alpha out.
// Hue comes in 2^-HUE_FRAC_BITS degree units (floored, 0 up to just under 360 degrees,
// low 15 bits kept), saturation is floor(255*delta/max), brightness is max, and alpha is
// passed through. Grey pixels give hue 0 and black pixels give saturation 0. The block
// takes one pixel every clock unless back-pressure has filled the pipe. Its stages are
// min/max, scaling, the pipelined restoring divider that resolves up to four hue quotient
// bits per stage with saturation divided alongside in the same stages, and the output.
// Back-pressure on m_ready stalls the pipe without losing words, and bubbles are squeezed out.
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rhc_pkg::COMP_W-1:0]   s_red,
    input  logic [rhc_pkg::COMP_W-1:0]   s_green,
    input  logic [rhc_pkg::COMP_W-1:0]   s_blue,
    input  logic [rhc_pkg::COMP_W-1:0]   s_alpha_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rhc_pkg::HUE_W-1:0]    m_hue,
    output logic [rhc_pkg::COMP_W-1:0]   m_saturation,
    output logic [rhc_pkg::COMP_W-1:0]   m_brightness,
    output logic [rhc_pkg::COMP_W-1:0]   m_alpha_out
);

    localparam int CW = rhc_pkg::COMP_W;
    localparam int NW = rhc_pkg::NUM_W;
    localparam int HUE_QW = 9 + HUE_FRAC_BITS;
    localparam int DIV_STAGES = (HUE_QW + 3) / 4;
    localparam int HUE_STEP = (HUE_QW + DIV_STAGES - 1) / DIV_STAGES;
    localparam int HUE_QPW = HUE_STEP * DIV_STAGES;
    localparam int SAT_STEP = (CW + DIV_STAGES - 1) / DIV_STAGES;
    localparam int SAT_QPW = SAT_STEP * DIV_STAGES;
    localparam int HUE_DVD_W = CW + HUE_QPW;
    localparam int SAT_DVD_W = CW + SAT_QPW;
    localparam int NUM60_W = NW + 6;
    localparam int HUE_TURN = rhc_pkg::TURN_DEG * (2 ** HUE_FRAC_BITS);
    localparam int HUE_EXT_W = (HUE_QPW > rhc_pkg::HUE_W) ? HUE_QPW : rhc_pkg::HUE_W;
    // min/max, scale, divider stages, output
    localparam int NSTG = DIV_STAGES + 3;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] vin;

    always_comb begin
        rdy[NSTG] = m_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign vin = {valid_reg[NSTG-2:0], s_valid};
    assign s_ready = rdy[0];
    assign m_valid = valid_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (rdy[i]) begin
                    valid_reg[i] <= vin[i];
                end
            end
        end
    end

    // stage 0: max, min, delta and sextant numerator
    rhc_pkg::comp_t mx_next;
    rhc_pkg::comp_t mn_next;
    rhc_pkg::comp_t delta_next;
    logic [NW-1:0]  num_next;
    logic           red_max;
    logic           green_max;

    always_comb begin
        red_max = (s_red >= s_green) && (s_red >= s_blue);
        green_max = !red_max && (s_green >= s_blue);
        mx_next = s_red;
        if (s_green > mx_next) mx_next = s_green;
        if (s_blue > mx_next) mx_next = s_blue;
        mn_next = s_red;
        if (s_green < mn_next) mn_next = s_green;
        if (s_blue < mn_next) mn_next = s_blue;
        delta_next = mx_next - mn_next;
        if (red_max) begin
            if (s_green >= s_blue) begin
                num_next = NW'(s_green) - NW'(s_blue);
            end else begin
                // negative red sextant wraps by a full turn
                num_next = NW'(NW'(delta_next) * NW'(rhc_pkg::SEXT_TURN))
                           - (NW'(s_blue) - NW'(s_green));
            end
        end else if (green_max) begin
            num_next = NW'(NW'(delta_next) * NW'(rhc_pkg::SEXT_GREEN))
                       + NW'(s_blue) - NW'(s_red);
        end else begin
            num_next = NW'(NW'(delta_next) * NW'(rhc_pkg::SEXT_BLUE))
                       + NW'(s_red) - NW'(s_green);
        end
    end

    rhc_pkg::side_t side_reg [NSTG-1];
    rhc_pkg::comp_t s0_delta_reg;
    logic [NW-1:0]  s0_num_reg;

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s0_delta_reg <= delta_next;
            s0_num_reg <= num_next;
            side_reg[0] <= '{grey: (delta_next == '0), mx: mx_next, alpha: s_alpha_in};
        end
    end

    for (genvar i = 1; i < NSTG - 1; i++) begin : g_side
        always_ff @(posedge aclk) begin
            if (rdy[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // stage 1: scale the dividends
    logic [NUM60_W-1:0]   num60;
    logic [HUE_DVD_W-1:0] hue_dvd_next;
    logic [SAT_DVD_W-1:0] sat_dvd_next;
    logic [HUE_DVD_W-1:0] hue_dvd_reg;
    logic [SAT_DVD_W-1:0] sat_dvd_reg;
    rhc_pkg::comp_t       s1_delta_reg;

    always_comb begin
        num60 = NUM60_W'(s0_num_reg) * NUM60_W'(rhc_pkg::HUE_DEG);
        hue_dvd_next = HUE_DVD_W'(num60) << HUE_FRAC_BITS;
        sat_dvd_next = SAT_DVD_W'(16'(s0_delta_reg) * 16'(rhc_pkg::SAT_SCALE));
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            hue_dvd_reg <= hue_dvd_next;
            sat_dvd_reg <= sat_dvd_next;
            s1_delta_reg <= s0_delta_reg;
        end
    end

    // divider stages
    logic [HUE_QPW-1:0] hue_quo;
    logic [SAT_QPW-1:0] sat_quo;

    rhc_div_pipe #(
        .STEP   (HUE_STEP),
        .STAGES (DIV_STAGES)
    ) u_hue_div (
        .aclk     (aclk),
        .stage_en (rdy[2 +: DIV_STAGES]),
        .dividend (hue_dvd_reg),
        .divisor  (s1_delta_reg),
        .quotient (hue_quo)
    );

    rhc_div_pipe #(
        .STEP   (SAT_STEP),
        .STAGES (DIV_STAGES)
    ) u_sat_div (
        .aclk     (aclk),
        .stage_en (rdy[2 +: DIV_STAGES]),
        .dividend (sat_dvd_reg),
        .divisor  (side_reg[1].mx),
        .quotient (sat_quo)
    );

    // output stage: wrap, clip to field width, zero the grey case
    rhc_pkg::side_t               side_last;
    logic [HUE_QPW-1:0]           hue_wrap;
    logic [HUE_EXT_W-1:0]         hue_ext;
    logic [rhc_pkg::HUE_W-1:0]    hue_next;
    rhc_pkg::comp_t               sat_next;
    logic [rhc_pkg::HUE_W-1:0]    hue_reg;
    rhc_pkg::comp_t               sat_reg;
    rhc_pkg::comp_t               bright_reg;
    rhc_pkg::comp_t               alpha_reg;

    assign side_last = side_reg[NSTG-2];

    always_comb begin
        hue_wrap = hue_quo;
        if (hue_quo >= HUE_QPW'(HUE_TURN)) begin
            hue_wrap = hue_quo - HUE_QPW'(HUE_TURN);
        end
        hue_ext = HUE_EXT_W'(hue_wrap);
        hue_next = side_last.grey ? '0 : hue_ext[rhc_pkg::HUE_W-1:0];
        sat_next = side_last.grey ? '0 : sat_quo[CW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy[NSTG-1]) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            bright_reg <= side_last.mx;
            alpha_reg <= side_last.alpha;
        end
    end

    assign m_hue = hue_reg;
    assign m_saturation = sat_reg;
    assign m_brightness = bright_reg;
    assign m_alpha_out = alpha_reg;

    `RHC_ASSERT(a_occupancy, aclk, aresetn, 1'b1 |=> $countones(valid_reg) == $past($countones(valid_reg)) + int'($past(s_valid && s_ready)) - int'($past(m_valid && m_ready)), "pipe occupancy does not match accepted and delivered words")
    `RHC_ASSERT(a_stall_full, aclk, aresetn, !s_ready |-> (&valid_reg) && !m_ready, "input stalled while the pipe has a bubble")
    `RHC_ASSERT_NEVER(a_hue_no_sat, aclk, aresetn, m_valid && m_saturation == '0 && m_hue != '0, "nonzero hue on a grey or black word")

endmodule

@@ tb/rgb_to_hsv_converter_tb.sv @@
module rgb_to_hsv_converter_tb;

    localparam int HUE_FRAC_BITS = 6;
    localparam int LATENCY = (9 + HUE_FRAC_BITS + 3) / 4 + 3;
    localparam int HUE_TURN = rhc_pkg::TURN_DEG << HUE_FRAC_BITS;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [rhc_pkg::HUE_W-1:0] hue;
        rhc_pkg::comp_t            saturation;
        rhc_pkg::comp_t            brightness;
        rhc_pkg::comp_t            alpha;
    } hsv_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    rhc_pkg::comp_t            s_red;
    rhc_pkg::comp_t            s_green;
    rhc_pkg::comp_t            s_blue;
    rhc_pkg::comp_t            s_alpha_in;
    logic                      m_valid;
    logic                      m_ready;
    logic [rhc_pkg::HUE_W-1:0] m_hue;
    rhc_pkg::comp_t            m_saturation;
    rhc_pkg::comp_t            m_brightness;
    rhc_pkg::comp_t            m_alpha_out;

    hsv_t pending_hsv[$];
    int   errors = 0;
    int   idle_cycles = 0;
    bit   no_idle = 1'b0;
    bit   hold_req = 1'b0;

    rgb_to_hsv_converter #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_red(s_red),
        .s_green(s_green),
        .s_blue(s_blue),
        .s_alpha_in(s_alpha_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_hue(m_hue),
        .m_saturation(m_saturation),
        .m_brightness(m_brightness),
        .m_alpha_out(m_alpha_out)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic hsv_t predict_hsv(rhc_pkg::comp_t r, rhc_pkg::comp_t g,
                                         rhc_pkg::comp_t b, rhc_pkg::comp_t a);
        hsv_t   res;
        int     ri;
        int     gi;
        int     bi;
        int     mx;
        int     mn;
        int     delta;
        int     num;
        longint h;
        ri = int'(r);
        gi = int'(g);
        bi = int'(b);
        mx = ri;
        mn = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        delta = mx - mn;
        h = 0;
        num = 0;
        if (delta != 0) begin
            // ties go to red, then green
            if (mx == ri) begin
                if (gi >= bi) num = gi - bi;
                else num = rhc_pkg::SEXT_TURN * delta - (bi - gi);
            end else if (mx == gi) begin
                num = rhc_pkg::SEXT_GREEN * delta + bi - ri;
            end else begin
                num = rhc_pkg::SEXT_BLUE * delta + ri - gi;
            end
            h = (longint'(rhc_pkg::HUE_DEG << HUE_FRAC_BITS) * longint'(num))
                / longint'(delta);
            if (h >= longint'(HUE_TURN)) h -= longint'(HUE_TURN);
        end
        res.hue = h[rhc_pkg::HUE_W-1:0];
        res.saturation = (mx == 0) ? '0 :
                         rhc_pkg::comp_t'((rhc_pkg::SAT_SCALE * delta) / mx);
        res.brightness = rhc_pkg::comp_t'(mx);
        res.alpha = a;
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (no_idle || roll < 60) return 0;
        if (roll < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    task automatic send_pixel(rhc_pkg::comp_t r, rhc_pkg::comp_t g, rhc_pkg::comp_t b,
                              rhc_pkg::comp_t a);
        int gap;
        s_valid <= 1'b1;
        s_red <= r;
        s_green <= g;
        s_blue <= b;
        s_alpha_in <= a;
        do @(posedge aclk); while (!s_ready);
        pending_hsv.push_back(predict_hsv(r, g, b, a));
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_hsv.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic send_random_pixel();
        rhc_pkg::comp_t r;
        rhc_pkg::comp_t g;
        rhc_pkg::comp_t b;
        rhc_pkg::comp_t a;
        r = rhc_pkg::comp_t'($urandom);
        g = rhc_pkg::comp_t'($urandom);
        b = rhc_pkg::comp_t'($urandom);
        a = rhc_pkg::comp_t'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                g = r;
                b = r;
            end
            1: g = r;
            2: b = g;
            3: b = r;
            4: begin
                r = rhc_pkg::comp_t'($urandom_range(0, 3));
                g = rhc_pkg::comp_t'($urandom_range(0, 3));
                b = rhc_pkg::comp_t'($urandom_range(0, 3));
            end
            5: r = 8'hff;
            default: ;
        endcase
        send_pixel(r, g, b, a);
    endtask

    task automatic test_directed();
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);         // black
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255); // white
        send_pixel(8'd128, 8'd128, 8'd128, 8'h55);  // grey
        send_pixel(8'd255, 8'd0, 8'd0, 8'haa);
        send_pixel(8'd0, 8'd255, 8'd0, 8'd1);
        send_pixel(8'd0, 8'd0, 8'd255, 8'd254);
        send_pixel(8'd255, 8'd255, 8'd0, 8'd7);     // red and green tie
        send_pixel(8'd0, 8'd255, 8'd255, 8'd9);     // green and blue tie
        send_pixel(8'd255, 8'd0, 8'd255, 8'd3);     // red and blue tie, wraps
        send_pixel(8'd255, 8'd0, 8'd1, 8'd4);       // just below a full turn
        send_pixel(8'd255, 8'd1, 8'd0, 8'd5);
        send_pixel(8'd1, 8'd0, 8'd0, 8'd6);
        send_pixel(8'd0, 8'd1, 8'd0, 8'd8);
        send_pixel(8'd0, 8'd0, 8'd1, 8'd10);
        send_pixel(8'd1, 8'd1, 8'd0, 8'd11);
        send_pixel(8'd200, 8'd100, 8'd50, 8'd12);
        send_pixel(8'd50, 8'd200, 8'd100, 8'd13);
        send_pixel(8'd100, 8'd50, 8'd200, 8'd14);
        send_pixel(8'd200, 8'd50, 8'd100, 8'd15);
        send_pixel(8'd254, 8'd255, 8'd253, 8'd16);
        send_pixel(8'd255, 8'd254, 8'd254, 8'd17);
        send_pixel(8'd1, 8'd255, 8'd0, 8'd18);
        wait_drained();
    endtask

    task automatic test_random();
        repeat (460) send_random_pixel();
    endtask

    task automatic test_back_pressure();
        no_idle = 1'b1;
        hold_req = 1'b1;
        repeat (60) send_random_pixel();
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (30) send_random_pixel();
        wait_drained();
        repeat (30) send_random_pixel();
    endtask

    task automatic test_full_rate();
        no_idle = 1'b1;
        repeat (100) send_random_pixel();
        no_idle = 1'b0;
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            int stall;
            @(posedge aclk);
            stall = pick_gap();
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        hsv_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hsv.size() == 0) begin
                $display("%0t: unexpected word hue %0d sat %0d val %0d alpha %0d", $time,
                         m_hue, m_saturation, m_brightness, m_alpha_out);
                errors++;
            end else begin
                want = pending_hsv.pop_front();
                if (m_hue !== want.hue) begin
                    $display("%0t: hue expected %0d, got %0d", $time, want.hue, m_hue);
                    errors++;
                end
                if (m_saturation !== want.saturation) begin
                    $display("%0t: saturation expected %0d, got %0d", $time,
                             want.saturation, m_saturation);
                    errors++;
                end
                if (m_brightness !== want.brightness) begin
                    $display("%0t: brightness expected %0d, got %0d", $time,
                             want.brightness, m_brightness);
                    errors++;
                end
                if (m_alpha_out !== want.alpha) begin
                    $display("%0t: alpha expected %0d, got %0d", $time, want.alpha,
                             m_alpha_out);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_red <= '0;
        s_green <= '0;
        s_blue <= '0;
        s_alpha_in <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_back_pressure();
        test_drain_pause();
        test_full_rate();
        wait_drained();
        repeat (LATENCY * 2) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
